// File: hw/rtl/stids_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stids_pkg
// Shared types and constants for the sorted key table: operation and status
// codes, controller states and the controller/datapath command bundles.
// ----------------------------------------------------------------------------
package stids_pkg;

  localparam int unsigned DefCapacity = 64;
  localparam int unsigned KeyW        = 32;
  localparam int unsigned FuncW       = 3;
  localparam int unsigned StatusW     = 3;
  localparam int unsigned CountOutW   = 7;

  typedef enum logic [FuncW-1:0] {
    FN_INSERT    = 3'd0,
    FN_DELETE    = 3'd1,
    FN_LOOKUP    = 3'd2,
    FN_RESET_CUR = 3'd3,
    FN_READ_NEXT = 3'd4,
    FN_EMPTY     = 3'd5
  } func_e;

  typedef enum logic [StatusW-1:0] {
    STS_OK        = 3'd0,
    STS_DUP       = 3'd1,
    STS_FULL      = 3'd2,
    STS_NOT_FOUND = 3'd3,
    STS_PAST_END  = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    ITEM_ZERO  = 2'd0,
    ITEM_KEY   = 2'd1,
    ITEM_RDATA = 2'd2
  } item_sel_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SRCH_RD,
    ST_SRCH_CMP,
    ST_DECIDE,
    ST_MV_PRIME,
    ST_MOVE,
    ST_PUT,
    ST_CUR_WAIT
  } state_e;

  typedef struct packed {
    logic      load;
    logic      srch_rd;
    logic      srch_cmp;
    logic      mv_init;
    logic      mv_rd;
    logic      mv_step;
    logic      put_key;
    logic      cur_rd;
    logic      cur_clr;
    logic      cur_inc;
    logic      cnt_clr;
    logic      cnt_dec;
    logic      finish;
    status_e   status;
    item_sel_e item_sel;
  } dp_cmd_t;

  typedef struct packed {
    func_e op;
    logic  srch_more;
    logic  found;
    logic  full;
    logic  mv_more;
    logic  mv_last;
    logic  cur_ok;
  } dp_sts_t;

endpackage

// File: hw/rtl/stids_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stids_ram
// Generic single-clock RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module stids_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/stids_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stids_ctrl
// Controller: sequences binary search, entry moves, cursor reads and the
// result beat for each command.
// ----------------------------------------------------------------------------
module stids_ctrl
  import stids_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start_i,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o,
  output logic    busy_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy_o  = (state_q != ST_IDLE);
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_EXEC;
        end
      end
      ST_EXEC: begin
        case (sts_i.op) inside
          FN_INSERT, FN_DELETE, FN_LOOKUP: begin
            state_d = ST_SRCH_RD;
          end
          FN_RESET_CUR: begin
            cmd_o.cur_clr = 1'b1;
            cmd_o.finish  = 1'b1;
            state_d       = ST_IDLE;
          end
          FN_READ_NEXT: begin
            if (sts_i.cur_ok) begin
              cmd_o.cur_rd = 1'b1;
              state_d      = ST_CUR_WAIT;
            end else begin
              cmd_o.finish = 1'b1;
              cmd_o.status = STS_PAST_END;
              state_d      = ST_IDLE;
            end
          end
          FN_EMPTY: begin
            cmd_o.cnt_clr = 1'b1;
            cmd_o.finish  = 1'b1;
            state_d       = ST_IDLE;
          end
          default: begin
            cmd_o.finish = 1'b1;
            state_d      = ST_IDLE;
          end
        endcase
      end
      ST_SRCH_RD: begin
        if (sts_i.srch_more) begin
          cmd_o.srch_rd = 1'b1;
          state_d       = ST_SRCH_CMP;
        end else begin
          state_d = ST_DECIDE;
        end
      end
      ST_SRCH_CMP: begin
        cmd_o.srch_cmp = 1'b1;
        state_d        = ST_SRCH_RD;
      end
      ST_DECIDE: begin
        state_d = ST_IDLE;
        case (sts_i.op)
          FN_INSERT: begin
            if (sts_i.found) begin
              cmd_o.finish = 1'b1;
              cmd_o.status = STS_DUP;
            end else if (sts_i.full) begin
              cmd_o.finish = 1'b1;
              cmd_o.status = STS_FULL;
            end else begin
              cmd_o.mv_init = 1'b1;
              state_d       = ST_MV_PRIME;
            end
          end
          FN_DELETE: begin
            if (sts_i.found) begin
              cmd_o.mv_init = 1'b1;
              state_d       = ST_MV_PRIME;
            end else begin
              cmd_o.finish = 1'b1;
              cmd_o.status = STS_NOT_FOUND;
            end
          end
          default: begin
            cmd_o.finish = 1'b1;
            if (sts_i.found) begin
              cmd_o.item_sel = ITEM_KEY;
            end else begin
              cmd_o.status = STS_NOT_FOUND;
            end
          end
        endcase
      end
      ST_MV_PRIME: begin
        if (sts_i.mv_more) begin
          cmd_o.mv_rd = 1'b1;
          state_d     = ST_MOVE;
        end else if (sts_i.op == FN_INSERT) begin
          state_d = ST_PUT;
        end else begin
          cmd_o.cnt_dec = 1'b1;
          cmd_o.finish  = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      ST_MOVE: begin
        cmd_o.mv_step = 1'b1;
        if (sts_i.mv_last) begin
          if (sts_i.op == FN_INSERT) begin
            state_d = ST_PUT;
          end else begin
            cmd_o.cnt_dec = 1'b1;
            cmd_o.finish  = 1'b1;
            state_d       = ST_IDLE;
          end
        end
      end
      ST_PUT: begin
        cmd_o.put_key = 1'b1;
        cmd_o.finish  = 1'b1;
        state_d       = ST_IDLE;
      end
      ST_CUR_WAIT: begin
        cmd_o.cur_inc  = 1'b1;
        cmd_o.finish   = 1'b1;
        cmd_o.item_sel = ITEM_RDATA;
        state_d        = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// File: hw/rtl/stids_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stids_dp
// Datapath: entry RAM, search bounds, move pointer, count, read cursor and
// the registered result beat.
// ----------------------------------------------------------------------------
module stids_dp
  import stids_pkg::*;
#(
  parameter int unsigned CAPACITY = DefCapacity
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  dp_cmd_t              cmd_i,
  input  logic [FuncW-1:0]     func_i,
  input  logic [KeyW-1:0]      key_i,
  output dp_sts_t              sts_o,
  output logic                 done_o,
  output logic [StatusW-1:0]   status_o,
  output logic [KeyW-1:0]      item_out_o,
  output logic [CountOutW-1:0] count_o,
  output logic                 full_res_o
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned AW = $clog2(CAPACITY);
  localparam logic [CW-1:0] CapC = CW'(CAPACITY);

  func_e          op_q;
  logic [KeyW-1:0] key_q;
  logic [CW-1:0]  lo_q, hi_q, ptr_q, mid;
  logic           found_q;
  logic [CW-1:0]  count_q, count_d;
  logic [CW-1:0]  cursor_q;
  logic           done_q;
  status_e        status_q;
  logic [KeyW-1:0] item_q;
  logic [CW-1:0]  res_count_q;
  logic           insert_op;

  logic            ram_we;
  logic [AW-1:0]   ram_waddr, ram_raddr;
  logic [KeyW-1:0] ram_wdata, ram_rdata;

  stids_ram #(
    .Width(KeyW),
    .Depth(CAPACITY),
    .AddrW(AW)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign insert_op = (op_q == FN_INSERT);
  assign mid       = lo_q + ((hi_q - lo_q) >> 1);

  always_comb begin
    if (cmd_i.srch_rd) begin
      ram_raddr = AW'(mid);
    end else if (cmd_i.mv_rd) begin
      ram_raddr = insert_op ? AW'(ptr_q - CW'(1)) : AW'(ptr_q);
    end else if (cmd_i.mv_step) begin
      ram_raddr = insert_op ? AW'(ptr_q - CW'(2)) : AW'(ptr_q + CW'(1));
    end else if (cmd_i.cur_rd) begin
      ram_raddr = AW'(cursor_q);
    end else begin
      ram_raddr = '0;
    end
  end

  assign ram_we    = cmd_i.mv_step | cmd_i.put_key;
  assign ram_wdata = cmd_i.put_key ? key_q : ram_rdata;

  always_comb begin
    if (cmd_i.put_key) begin
      ram_waddr = AW'(lo_q);
    end else if (insert_op) begin
      ram_waddr = AW'(ptr_q);
    end else begin
      ram_waddr = AW'(ptr_q - CW'(1));
    end
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.cnt_clr) begin
      count_d = '0;
    end else if (cmd_i.put_key) begin
      count_d = count_q + CW'(1);
    end else if (cmd_i.cnt_dec) begin
      count_d = count_q - CW'(1);
    end
  end

  // Search bounds, move pointer and latched command.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q    <= func_e'(func_i);
      key_q   <= key_i;
      lo_q    <= '0;
      hi_q    <= count_q;
      found_q <= 1'b0;
    end else if (cmd_i.srch_cmp) begin
      if (ram_rdata < key_q) begin
        lo_q <= mid + CW'(1);
      end else begin
        hi_q <= mid;
      end
      if (ram_rdata == key_q) begin
        found_q <= 1'b1;
      end
    end
    if (cmd_i.mv_init) begin
      ptr_q <= insert_op ? count_q : lo_q + CW'(1);
    end else if (cmd_i.mv_step) begin
      ptr_q <= insert_op ? ptr_q - CW'(1) : ptr_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      cursor_q <= '0;
      done_q   <= 1'b0;
    end else begin
      count_q <= count_d;
      done_q  <= cmd_i.finish;
      if (cmd_i.cur_clr) begin
        cursor_q <= '0;
      end else if (cmd_i.cur_inc) begin
        cursor_q <= cursor_q + CW'(1);
      end
    end
  end

  // Result beat.
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      status_q    <= cmd_i.status;
      res_count_q <= count_d;
      case (cmd_i.item_sel)
        ITEM_KEY:   item_q <= key_q;
        ITEM_RDATA: item_q <= ram_rdata;
        default:    item_q <= '0;
      endcase
    end
  end

  always_comb begin
    sts_o.op        = op_q;
    sts_o.srch_more = (lo_q < hi_q);
    sts_o.found     = found_q;
    sts_o.full      = (count_q >= CapC);
    sts_o.mv_more   = insert_op ? (ptr_q > lo_q) : (ptr_q < count_q);
    sts_o.mv_last   = insert_op ? ((ptr_q - CW'(1)) <= lo_q) : ((ptr_q + CW'(1)) >= count_q);
    sts_o.cur_ok    = (cursor_q < count_q);
  end

  assign done_o     = done_q;
  assign status_o   = status_q;
  assign item_out_o = item_q;
  assign count_o    = CountOutW'(res_count_q);
  assign full_res_o = (res_count_q == CapC);

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CapC)
    else $error("entry count above capacity");

  a_search_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.srch_cmp |=> lo_q <= hi_q)
    else $error("search bounds crossed");

  a_put_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.put_key |-> (!found_q && count_q < CapC))
    else $error("key written for duplicate or into full table");

  a_cursor_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.cur_rd |-> cursor_q < count_q)
    else $error("cursor read beyond held entries");

  a_single_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("result strobe longer than one cycle");

endmodule

// File: hw/rtl/sorted_table_insert_delete_search_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_table_insert_delete_search_unit
// Sorted table of unique 32-bit keys with insert, delete, binary-search
// lookup, in-order read cursor and empty.
// ----------------------------------------------------------------------------
// A command (func_i, key_i) is taken when start_i is high and busy_o is low.
// Exactly one result beat follows per command: done_o is high for one cycle
// with status_o, item_out_o, count_o and full_res_o, and the receiver cannot
// stall it, so capture the beat when done_o is seen. Lookup, insert and
// delete run a binary search over the entry RAM; insert and delete then move
// one entry per cycle through the RAM's one read and one write port. A new
// command can be started in the strobe cycle.
// ----------------------------------------------------------------------------
module sorted_table_insert_delete_search_unit
  import stids_pkg::*;
#(
  parameter int unsigned CAPACITY = DefCapacity
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [FuncW-1:0]     func_i,
  input  logic [KeyW-1:0]      key_i,
  output logic                 busy_o,
  output logic                 done_o,
  output logic [StatusW-1:0]   status_o,
  output logic [KeyW-1:0]      item_out_o,
  output logic [CountOutW-1:0] count_o,
  output logic                 full_res_o
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  stids_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy_o (busy_o)
  );

  stids_dp #(
    .CAPACITY(CAPACITY)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .func_i    (func_i),
    .key_i     (key_i),
    .sts_o     (sts),
    .done_o    (done_o),
    .status_o  (status_o),
    .item_out_o(item_out_o),
    .count_o   (count_o),
    .full_res_o(full_res_o)
  );

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sorted key table unit. A short table of
// directed commands walks the corner cases, then biased random bursts fill,
// drain, scan and mix the table. Every accepted command is run through an
// in-bench model of the table and each done beat is compared field by field.
// ----------------------------------------------------------------------------
module tb_top;
  import stids_pkg::*;

  localparam int unsigned Cap      = DefCapacity;
  localparam int          RandCmds = 1900;
  localparam int          TailWait = 120;

  localparam logic [FuncW-1:0] FN_SPARE_A = 3'd6;
  localparam logic [FuncW-1:0] FN_SPARE_B = 3'd7;

  typedef struct packed {
    status_e              status;
    logic [KeyW-1:0]      item;
    logic [CountOutW-1:0] count;
    logic                 full;
  } table_beat_t;

  typedef struct {
    logic [FuncW-1:0]     fn;
    logic [KeyW-1:0]      key;
    bit                   typed;
    status_e              status;
    logic [KeyW-1:0]      item;
    logic [CountOutW-1:0] count;
    logic                 full;
  } script_row_t;

  typedef enum int { MODE_FILL, MODE_DRAIN, MODE_MIX, MODE_SCAN } mix_mode_e;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 start_i;
  logic [FuncW-1:0]     func_i;
  logic [KeyW-1:0]      key_i;
  logic                 busy_o;
  logic                 done_o;
  logic [StatusW-1:0]   status_o;
  logic [KeyW-1:0]      item_out_o;
  logic [CountOutW-1:0] count_o;
  logic                 full_res_o;

  logic [KeyW-1:0] keys_held [Cap];
  int              keys_cnt;
  int              cursor_pos;

  table_beat_t expected_beats[$];
  int          errors;
  int          cmds_sent;
  int          beats_seen;
  int          status_hits [5];
  int          full_hits;
  int          idle_pct;

  sorted_table_insert_delete_search_unit #(
    .CAPACITY(Cap)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .func_i     (func_i),
    .key_i      (key_i),
    .busy_o     (busy_o),
    .done_o     (done_o),
    .status_o   (status_o),
    .item_out_o (item_out_o),
    .count_o    (count_o),
    .full_res_o (full_res_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic table_beat_t apply_cmd(input logic [FuncW-1:0] fn,
                                            input logic [KeyW-1:0] k);
    table_beat_t r;
    int          pos;
    bit          hit;
    r.status = STS_OK;
    r.item   = '0;
    pos = 0;
    while (pos < keys_cnt && keys_held[pos] < k) pos++;
    hit = (pos < keys_cnt) && (keys_held[pos] == k);
    case (fn)
      FN_INSERT: begin
        if (hit) begin
          r.status = STS_DUP;
        end else if (keys_cnt >= Cap) begin
          r.status = STS_FULL;
        end else begin
          for (int i = keys_cnt; i > pos; i--) keys_held[i] = keys_held[i-1];
          keys_held[pos] = k;
          keys_cnt++;
        end
      end
      FN_DELETE: begin
        if (hit) begin
          for (int i = pos + 1; i < keys_cnt; i++) keys_held[i-1] = keys_held[i];
          keys_cnt--;
        end else begin
          r.status = STS_NOT_FOUND;
        end
      end
      FN_LOOKUP: begin
        if (hit) r.item = keys_held[pos];
        else r.status = STS_NOT_FOUND;
      end
      FN_RESET_CUR: cursor_pos = 0;
      FN_READ_NEXT: begin
        if (cursor_pos < keys_cnt && cursor_pos < Cap) begin
          r.item = keys_held[cursor_pos];
          cursor_pos++;
        end else begin
          r.status = STS_PAST_END;
        end
      end
      FN_EMPTY: keys_cnt = 0;
      default: ;
    endcase
    r.count = keys_cnt[CountOutW-1:0];
    r.full  = (keys_cnt == Cap);
    return r;
  endfunction

  task automatic send_cmd(input logic [FuncW-1:0] fn, input logic [KeyW-1:0] k,
                          input bit typed, input table_beat_t typed_beat);
    table_beat_t beat;
    @(negedge clk_i);
    if ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    start_i <= 1'b1;
    func_i  <= fn;
    key_i   <= k;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    beat = apply_cmd(fn, k);
    expected_beats.push_back(typed ? typed_beat : beat);
    cmds_sent++;
  endtask

  function automatic logic [KeyW-1:0] pick_key(input int hit_pct);
    int roll;
    roll = $urandom_range(99);
    if (keys_cnt > 0 && roll < hit_pct) return keys_held[$urandom_range(keys_cnt - 1)];
    roll = $urandom_range(99);
    if (roll < 8) return '0;
    if (roll < 16) return '1;
    if (roll < 40) return $urandom_range(255);
    return $urandom;
  endfunction

  task automatic run_random(input int cmds);
    int               left;
    int               burst;
    int               roll;
    mix_mode_e        mode;
    logic [FuncW-1:0] fn;
    logic [FuncW-1:0] spare;
    logic [KeyW-1:0]  k;
    table_beat_t      blank;
    blank = '0;
    left  = cmds;
    while (left > 0) begin
      mode  = mix_mode_e'($urandom_range(3));
      burst = $urandom_range(30, 120);
      while (burst > 0 && left > 0) begin
        roll  = $urandom_range(99);
        spare = $urandom_range(1) ? FN_SPARE_A : FN_SPARE_B;
        case (mode)
          MODE_FILL:
            fn = roll < 72 ? FN_INSERT : roll < 82 ? FN_LOOKUP : roll < 88 ? FN_DELETE :
                 roll < 94 ? FN_READ_NEXT : roll < 97 ? FN_RESET_CUR : spare;
          MODE_DRAIN:
            fn = roll < 55 ? FN_DELETE : roll < 70 ? FN_LOOKUP : roll < 80 ? FN_INSERT :
                 roll < 92 ? FN_READ_NEXT : roll < 96 ? FN_RESET_CUR : spare;
          MODE_SCAN:
            fn = burst == 1 || roll < 6 ? FN_RESET_CUR : roll < 72 ? FN_READ_NEXT :
                 roll < 82 ? FN_LOOKUP : roll < 90 ? FN_INSERT : FN_DELETE;
          default:
            fn = roll < 30 ? FN_INSERT : roll < 50 ? FN_DELETE : roll < 70 ? FN_LOOKUP :
                 roll < 84 ? FN_READ_NEXT : roll < 92 ? FN_RESET_CUR :
                 roll < 97 ? spare : FN_EMPTY;
        endcase
        case (fn)
          FN_INSERT: k = pick_key(15);
          FN_DELETE, FN_LOOKUP: k = pick_key(70);
          default: k = $urandom;
        endcase
        send_cmd(fn, k, 1'b0, blank);
        burst--;
        left--;
      end
    end
  endtask

  always @(posedge clk_i) begin
    table_beat_t want;
    if (rst_ni && done_o === 1'b1) begin
      beats_seen++;
      if (status_o < 5) status_hits[status_o]++;
      if (full_res_o === 1'b1) full_hits++;
      if (expected_beats.size() == 0) begin
        $error("unexpected done beat: status %0d item %h count %0d",
               status_o, item_out_o, count_o);
        errors++;
      end else begin
        want = expected_beats.pop_front();
        if (status_o !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status_o);
          errors++;
        end
        if (item_out_o !== want.item) begin
          $error("item_out: expected %h, got %h", want.item, item_out_o);
          errors++;
        end
        if (count_o !== want.count) begin
          $error("count: expected %0d, got %0d", want.count, count_o);
          errors++;
        end
        if (full_res_o !== want.full) begin
          $error("full_res: expected %0b, got %0b", want.full, full_res_o);
          errors++;
        end
      end
    end
  end

  initial begin
    #10_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    script_row_t script [25];
    table_beat_t typed_beat;
    errors     = 0;
    cmds_sent  = 0;
    beats_seen = 0;
    full_hits  = 0;
    keys_cnt   = 0;
    cursor_pos = 0;
    idle_pct   = 23;
    foreach (status_hits[i]) status_hits[i] = 0;
    foreach (keys_held[i]) keys_held[i] = '0;
    rst_ni  = 1'b0;
    start_i = 1'b0;
    func_i  = FN_INSERT;
    key_i   = '0;
    script = '{
      '{FN_READ_NEXT, 32'h0000_0000, 1, STS_PAST_END,  32'h0000_0000, 7'd0, 1'b0},
      '{FN_LOOKUP,    32'h0000_0000, 1, STS_NOT_FOUND, 32'h0000_0000, 7'd0, 1'b0},
      '{FN_DELETE,    32'hFFFF_FFFF, 1, STS_NOT_FOUND, 32'h0000_0000, 7'd0, 1'b0},
      '{FN_INSERT,    32'h0000_0000, 1, STS_OK,        32'h0000_0000, 7'd1, 1'b0},
      '{FN_INSERT,    32'hFFFF_FFFF, 1, STS_OK,        32'h0000_0000, 7'd2, 1'b0},
      '{FN_INSERT,    32'h0000_0000, 1, STS_DUP,       32'h0000_0000, 7'd2, 1'b0},
      '{FN_INSERT,    32'h8000_0000, 1, STS_OK,        32'h0000_0000, 7'd3, 1'b0},
      '{FN_LOOKUP,    32'hFFFF_FFFF, 1, STS_OK,        32'hFFFF_FFFF, 7'd3, 1'b0},
      '{FN_LOOKUP,    32'h7FFF_FFFF, 1, STS_NOT_FOUND, 32'h0000_0000, 7'd3, 1'b0},
      '{FN_READ_NEXT, 32'hAAAA_AAAA, 1, STS_OK,        32'h0000_0000, 7'd3, 1'b0},
      '{FN_READ_NEXT, 32'h5555_5555, 1, STS_OK,        32'h8000_0000, 7'd3, 1'b0},
      '{FN_READ_NEXT, 32'h0000_0000, 1, STS_OK,        32'hFFFF_FFFF, 7'd3, 1'b0},
      '{FN_READ_NEXT, 32'h0000_0000, 1, STS_PAST_END,  32'h0000_0000, 7'd3, 1'b0},
      '{FN_RESET_CUR, 32'h5555_5555, 1, STS_OK,        32'h0000_0000, 7'd3, 1'b0},
      '{FN_SPARE_A,   32'h1234_5678, 1, STS_OK,        32'h0000_0000, 7'd3, 1'b0},
      '{FN_SPARE_B,   32'hFFFF_FFFF, 1, STS_OK,        32'h0000_0000, 7'd3, 1'b0},
      '{FN_READ_NEXT, 32'h0000_0000, 1, STS_OK,        32'h0000_0000, 7'd3, 1'b0},
      '{FN_DELETE,    32'h0000_0000, 1, STS_OK,        32'h0000_0000, 7'd2, 1'b0},
      '{FN_READ_NEXT, 32'h0000_0000, 1, STS_OK,        32'hFFFF_FFFF, 7'd2, 1'b0},
      '{FN_DELETE,    32'h0000_0000, 1, STS_NOT_FOUND, 32'h0000_0000, 7'd2, 1'b0},
      '{FN_INSERT,    32'h0000_0001, 1, STS_OK,        32'h0000_0000, 7'd3, 1'b0},
      '{FN_READ_NEXT, 32'h0000_0000, 1, STS_OK,        32'hFFFF_FFFF, 7'd3, 1'b0},
      '{FN_EMPTY,     32'hFFFF_FFFF, 1, STS_OK,        32'h0000_0000, 7'd0, 1'b0},
      '{FN_READ_NEXT, 32'h0000_0000, 1, STS_PAST_END,  32'h0000_0000, 7'd0, 1'b0},
      '{FN_INSERT,    32'h1234_5678, 0, STS_OK,        32'h0000_0000, 7'd0, 1'b0}
    };
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (script[i]) begin
      typed_beat = '{script[i].status, script[i].item, script[i].count, script[i].full};
      send_cmd(script[i].fn, script[i].key, script[i].typed, typed_beat);
    end

    idle_pct = 23;
    run_random(RandCmds / 3);
    idle_pct = 55;
    run_random(RandCmds / 3);
    idle_pct = 0;
    run_random(RandCmds - 2 * (RandCmds / 3));

    @(negedge clk_i);
    start_i <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk_i);
    repeat (TailWait) @(posedge clk_i);

    $display("Sent %0d commands, checked %0d beats, %0d with the table full",
             cmds_sent, beats_seen, full_hits);
    $display("Status mix: ok %0d, dup %0d, full %0d, not found %0d, past end %0d",
             status_hits[0], status_hits[1], status_hits[2], status_hits[3],
             status_hits[4]);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: files.f
hw/rtl/stids_pkg.sv
hw/rtl/stids_ram.sv
hw/rtl/stids_ctrl.sv
hw/rtl/stids_dp.sv
hw/rtl/sorted_table_insert_delete_search_unit.sv
bench/tb_top.sv
